[rtl/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants, datapath command bundle and controller state encoding
// for the tour length evaluator.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int MAX_CITIES_DEF = 64;
    localparam int IDX_W          = 6;
    localparam int COORD_W        = 24;
    localparam int SUM_W          = 32;
    localparam int SQ_W           = 2 * COORD_W;      // one squared coordinate delta
    localparam int RAD_W          = SQ_W + 1;         // sum of two squares
    localparam int ROOT_W         = (RAD_W + 1) / 2;  // bits of the integer root
    localparam int ROOT_STEPS     = ROOT_W;           // one root bit per cycle
    localparam int CNT_W          = $clog2(ROOT_STEPS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TOUR = 1'b1;

    // Commands from the controller to the datapath, at most one per cycle
    typedef struct packed {
        logic mem_wr;      // write one city's coordinates
        logic mem_rd;      // read the city of a tour beat
        logic open_tour;   // capture first and previous city, clear the sum
        logic load_step;   // deltas previous -> current, advance previous
        logic load_close;  // deltas last -> first city
        logic mul_x;       // square dx
        logic mul_y;       // square dy
        logic root_init;   // form radicand, reset the root unit
        logic root_step;   // one root bit
        logic accum;       // add the leg, saturating
        logic emit;        // load the result register
    } tle_cmd_t;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_READ      = 9'b000000010,
        ST_MUL_X     = 9'b000000100,
        ST_MUL_Y     = 9'b000001000,
        ST_ROOT_INIT = 9'b000010000,
        ST_ROOT      = 9'b000100000,
        ST_ACCUM     = 9'b001000000,
        ST_CLOSE     = 9'b010000000,
        ST_EMIT      = 9'b100000000
    } tle_state_t;

endpackage

[rtl/tle_ctrl.sv]
// ----------------------------------------------------------------------------
// tle_ctrl
// Sequencer: takes input beats, steps the datapath through each leg and
// holds the result valid flag.
// ----------------------------------------------------------------------------
module tle_ctrl
    import tle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     operation,
    input  logic     last_city,
    output logic     out_valid,
    input  logic     out_ready,
    output tle_cmd_t cmd
);

    tle_state_t       state_reg, state_next;
    logic             last_reg, last_next;
    logic             closing_reg, closing_next;
    logic             open_reg, open_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        closing_next   = closing_reg;
        open_next      = open_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        // drop the result once taken; a new one below overrides
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.mem_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.mem_rd = 1'b1;
                        last_next  = last_city;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (open_reg)
                begin
                    cmd.load_step = 1'b1;
                    closing_next  = 1'b0;
                    state_next    = ST_MUL_X;
                end
                else
                begin
                    // opening city: no leg yet, a one-city tour emits zero
                    cmd.open_tour = 1'b1;
                    open_next     = 1'b1;
                    state_next    = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_MUL_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = ST_ROOT_INIT;
            end
            ST_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (last_reg && !closing_reg)
                begin
                    state_next = ST_CLOSE;
                end
                else if (last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE:
            begin
                cmd.load_close = 1'b1;
                closing_next   = 1'b1;
                state_next     = ST_MUL_X;
            end
            ST_EMIT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    open_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            closing_reg   <= 1'b0;
            open_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            closing_reg   <= closing_next;
            open_reg      <= open_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/tle_datapath.sv]
// ----------------------------------------------------------------------------
// tle_datapath
// Coordinate store, tour registers, squarer, bit-serial integer square root
// and saturating length accumulator.
// ----------------------------------------------------------------------------
module tle_datapath
    import tle_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tle_cmd_t           cmd,
    input  logic [IDX_W-1:0]   city_index,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    output logic [SUM_W-1:0]   tour_length
);

    localparam int ADDR_W = $clog2(MAX_CITIES);
    localparam int ENTRY_W = 2 * COORD_W;

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [ENTRY_W-1:0] mem [MAX_CITIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               in_range_reg;

    logic [31:0]        idx_ext;
    logic [ADDR_W-1:0]  addr;
    logic               in_range;
    logic [ENTRY_W-1:0] cur;
    logic [ENTRY_W-1:0] opnd_b;

    logic [ENTRY_W-1:0] first_reg;
    logic [ENTRY_W-1:0] prev_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [RAD_W-1:0]   rem_reg;
    logic [RAD_W-1:0]   res_reg;
    logic [RAD_W-1:0]   bit_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   tour_length_reg;

    logic [COORD_W-1:0] sq_opnd;
    logic [SQ_W-1:0]    sq_prod;
    logic [RAD_W:0]     trial;
    logic [SUM_W:0]     sum_wide;

    assign idx_ext  = 32'(city_index);
    assign addr     = idx_ext[ADDR_W-1:0];
    assign in_range = idx_ext < 32'(MAX_CITIES);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && in_range)
        begin
            mem[addr] <= {x_coord, y_coord};
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg  <= mem[addr];
            in_range_reg <= in_range;
        end
    end

    // out-of-range cities sit at the origin
    assign cur    = in_range_reg ? rd_data_reg : '0;
    assign opnd_b = cmd.load_close ? first_reg : cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            prev_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cmd.open_tour)
            begin
                first_reg <= cur;
                prev_reg  <= cur;
                sum_reg   <= '0;
            end
            if (cmd.load_step)
            begin
                prev_reg <= cur;
            end
            if (cmd.accum)
            begin
                sum_reg <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
            end
        end
    end

    // one 24x24 squarer, shared by dx and dy on consecutive cycles
    assign sq_opnd  = cmd.mul_y ? dy_reg : dx_reg;
    assign sq_prod  = {{COORD_W{1'b0}}, sq_opnd} * {{COORD_W{1'b0}}, sq_opnd};
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(res_reg[ROOT_W-1:0]);
    assign trial    = {1'b0, res_reg} + {1'b0, bit_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_step || cmd.load_close)
        begin
            dx_reg <= abs_diff(prev_reg[ENTRY_W-1:COORD_W], opnd_b[ENTRY_W-1:COORD_W]);
            dy_reg <= abs_diff(prev_reg[COORD_W-1:0], opnd_b[COORD_W-1:0]);
        end
        if (cmd.mul_x)
        begin
            sqx_reg <= sq_prod;
        end
        if (cmd.mul_y)
        begin
            sqy_reg <= sq_prod;
        end
        if (cmd.root_init)
        begin
            rem_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            res_reg <= '0;
            bit_reg <= {1'b1, {(RAD_W - 1){1'b0}}};
        end
        else if (cmd.root_step)
        begin
            // one restoring step: try res + bit, keep it if it fits
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_reg <= rem_reg - trial[RAD_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.emit)
        begin
            tour_length_reg <= sum_reg;
        end
    end

    assign tour_length = tour_length_reg;

endmodule

[rtl/tour_length_evaluator.sv]
// ----------------------------------------------------------------------------
// tour_length_evaluator
// Closed Euclidean tour length over a store of city coordinates.
// ----------------------------------------------------------------------------
// Load beats write one city's 16.8 coordinates into the store. Tour beats
// name cities in visiting order; the block takes one beat at a time. The
// opening city of a tour is read and taken as first and previous city. Every
// later city runs the store read, the deltas, squaring of dx then dy on a
// shared 24x24 multiplier, radicand set-up, the bit-serial square root (one
// root bit per cycle) and the accumulate; the city marked last then runs the
// return leg and loads the result register once it is free. The root unit
// sets the rate. The result register lets the next tour start while the
// previous length is still waiting to be taken. Lengths are 24.8, saturating
// at all ones; a city index at or beyond MAX_CITIES reads as the origin and
// a load to it is dropped. Reading a city never loaded gives an undefined leg.
// ----------------------------------------------------------------------------
module tour_length_evaluator
    import tle_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [IDX_W-1:0]   city_index,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    input  logic               last_city,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SUM_W-1:0]   tour_length
);

    tle_cmd_t cmd;

    tle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .last_city (last_city),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tle_datapath #(
        .MAX_CITIES (MAX_CITIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .city_index  (city_index),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .tour_length (tour_length)
    );

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mem_wr, cmd.mem_rd, cmd.open_tour, cmd.load_step, cmd.load_close,
                  cmd.mul_x, cmd.mul_y, cmd.root_init, cmd.root_step, cmd.accum,
                  cmd.emit}))
        else $error("more than one datapath command in a cycle");

    a_read_on_tour_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd |-> (in_valid && in_ready && operation == OP_TOUR))
        else $error("store read without an accepted tour beat");

    a_busy_after_tour_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd |=> !in_ready)
        else $error("new beat taken while a tour city is in flight");

    a_square_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_x |=> cmd.mul_y ##1 cmd.root_init)
        else $error("squaring sequence broken");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("result loaded without valid");

endmodule
